// ===== rtl/fat_pkg.sv =====
// ============================================================================
// fat_pkg
// Shared types and codes of the flow aggregation table.
// ============================================================================
package fat_pkg;

   localparam int ENTRIES_DEF  = 1024;
   localparam int SLOTS_DEF    = 4;
   localparam int KEY_BITS_DEF = 128;

   localparam int MODE_REGS = 4;

   // Operation codes carried in the request word.
   localparam logic [1:0] OP_OBSERVE = 2'd0;
   localparam logic [1:0] OP_MERGE   = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   // Slot aggregate kinds.
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_SUM   = 3'd1;
   localparam logic [2:0] KIND_MIN   = 3'd2;
   localparam logic [2:0] KIND_MAX   = 3'd3;
   localparam logic [2:0] KIND_COUNT = 3'd4;

   // Slot width codes.
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   localparam logic [1:0] DIR_ANY = 2'd0;

   typedef struct packed {
      logic [1:0] dir;
      logic [1:0] width;
      logic       sgn;
      logic [2:0] kind;
   } slot_mode_type;

endpackage

// ===== rtl/fat_ram.sv =====
// ============================================================================
// fat_ram
// Generic single-write, single-read memory with registered read data.
// ============================================================================
module fat_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/fat_slot.sv =====
// ============================================================================
// fat_slot
// Fold unit for one aggregate slot: identity, masking, sum, min, max, count.
// ============================================================================
module fat_slot (
   input  fat_pkg::slot_mode_type mode,
   input  logic [1:0]             op,
   input  logic                   hit,
   input  logic [1:0]             flow_dir,
   input  logic                   present,
   input  logic [63:0]            operand,
   input  logic [63:0]            stored,
   output logic                   active,
   output logic [63:0]            new_value
);
   import fat_pkg::*;

   logic [63:0] m;
   logic [63:0] sbit;
   logic [63:0] ident;
   logic [63:0] base;
   logic [63:0] acc;
   logic [63:0] v;
   logic [63:0] v_eff;
   logic [63:0] acc_c;
   logic [63:0] v_c;
   logic        v_lt_acc;
   logic [63:0] folded;
   logic        filt_ok;
   logic        en;

   always_comb begin
      active = (mode.kind == KIND_SUM) || (mode.kind == KIND_MIN) ||
               (mode.kind == KIND_MAX) || (mode.kind == KIND_COUNT);
      case (mode.width)
         WIDTH_8:  m = 64'h0000_0000_0000_00FF;
         WIDTH_16: m = 64'h0000_0000_0000_FFFF;
         WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
         default:  m = '1;
      endcase
      if (mode.kind == KIND_COUNT) begin
         m = '1;
      end
      sbit = (m >> 1) + 64'd1;

      case (mode.kind)
         KIND_MIN: ident = mode.sgn ? (m >> 1) : m;
         KIND_MAX: ident = mode.sgn ? (sbit & m) : 64'd0;
         default:  ident = 64'd0;
      endcase

      if (hit) begin
         base = stored;
      end else if (op == OP_OBSERVE) begin
         base = ident;
      end else begin
         base = operand & m;
      end

      acc   = base & m;
      v     = operand & m;
      v_eff = ((op == OP_OBSERVE) && (mode.kind == KIND_COUNT)) ? 64'd1 : v;

      // Signed compare by flipping the sign bit of the slot width.
      acc_c    = mode.sgn ? (acc ^ sbit) : acc;
      v_c      = mode.sgn ? (v ^ sbit) : v;
      v_lt_acc = v_c < acc_c;

      case (mode.kind)
         KIND_SUM, KIND_COUNT: folded = (acc + v_eff) & m;
         KIND_MIN:             folded = v_lt_acc ? v : acc;
         KIND_MAX:             folded = (acc_c < v_c) ? v : acc;
         default:              folded = acc;
      endcase

      filt_ok = (mode.dir == DIR_ANY) || (mode.dir == flow_dir);
      if (op == OP_OBSERVE) begin
         en = filt_ok && ((mode.kind == KIND_COUNT) || present);
      end else begin
         en = hit;
      end

      if (!active) begin
         new_value = hit ? stored : 64'd0;
      end else if (en) begin
         new_value = folded;
      end else begin
         new_value = base;
      end
   end

endmodule

// ===== rtl/flow_aggregation_table_top.sv =====
// ============================================================================
// flow_aggregation_table_top
// Keyed flow aggregation table with configurable per-slot aggregates.
// ============================================================================
//
//  Channel   Direction  Handshake          Contents
//  req_      in         tvalid/tready      one operation word (observe/merge/read)
//  rsp_      out        tvalid/tready      one result word per operation
//  csr_      in         write enable only  slot mode registers 0..3
//
// An observe or merge scans the key memory linearly, one entry per cycle, in
// creation order, and stops at a match or after the last filled entry. The key
// memory read port sets the scan rate. Reset clears the fill count and mode
// registers; the memories need no clearing pass because only filled entries
// are ever read. One word is worked on at a time; a result waiting in the
// output register holds the block in its final state until the word is taken.
// ============================================================================
module flow_aggregation_table_top #(
   parameter int ENTRIES  = fat_pkg::ENTRIES_DEF,
   parameter int SLOTS    = fat_pkg::SLOTS_DEF,
   parameter int KEY_BITS = fat_pkg::KEY_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata from bit 0: key_high(64), key_low(64), flow_direction(2),
   // present_mask(4), value_a(64), value_b(64), value_c(64), value_d(64),
   // read_index(10)
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [399:0] req_tdata,
   // req_tuser: op(2)
   input  logic [1:0]   req_tuser,
   // rsp_tdata from bit 0: entry_position(10), out_key_high(64),
   // out_key_low(64), out_value_a(64), out_value_b(64), out_value_c(64),
   // out_value_d(64), zero fill(6)
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [399:0] rsp_tdata,
   // rsp_tuser from bit 0: hit, table_full, entry_valid
   output logic [2:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);
   import fat_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int AW = 64 * SLOTS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_UPD  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]          state_ff, state_in;
   slot_mode_type       mode_ff [MODE_REGS];
   logic [CW-1:0]       count_ff, count_in;

   // Latched request word.
   logic [1:0]          op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [1:0]          dir_ff, dir_in;
   logic [3:0]          pm_ff, pm_in;
   logic [63:0]         val_ff [SLOTS];
   logic [63:0]         val_in [SLOTS];

   // Scan control.
   logic [CW-1:0]       scan_ff, scan_in;
   logic                pend_ff, pend_in;
   logic [IW-1:0]       pidx_ff, pidx_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                hit_ff, hit_in;

   // Result staging.
   logic                res_hit_ff, res_hit_in;
   logic                res_full_ff, res_full_in;
   logic                res_valid_ff, res_valid_in;
   logic [9:0]          res_pos_ff, res_pos_in;
   logic [127:0]        res_key_ff, res_key_in;
   logic [63:0]         res_val_ff [SLOTS];
   logic [63:0]         res_val_in [SLOTS];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [399:0]        rsp_data_ff, rsp_data_in;
   logic [2:0]          rsp_user_ff, rsp_user_in;

   logic                key_we;
   logic [IW-1:0]       key_raddr;
   logic [KEY_BITS-1:0] key_rdata;
   logic                agg_we;
   logic [IW-1:0]       agg_raddr;
   logic [AW-1:0]       agg_wdata;
   logic [AW-1:0]       agg_rdata;

   logic [63:0]         slot_new [SLOTS];
   logic                slot_act [SLOTS];
   logic [63:0]         rd_vals [4];
   logic                accept;
   logic                ridx_ok;
   logic                match;
   logic                out_free;

   fat_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (idx_ff),
      .wdata (key_ff),
      .raddr (key_raddr),
      .rdata (key_rdata)
   );

   fat_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_agg_ram (
      .clock (clock),
      .we    (agg_we),
      .waddr (idx_ff),
      .wdata (agg_wdata),
      .raddr (agg_raddr),
      .rdata (agg_rdata)
   );

   for (genvar k = 0; k < SLOTS; k++) begin : g_slot
      fat_slot u_slot (
         .mode      (mode_ff[k]),
         .op        (op_ff),
         .hit       (hit_ff),
         .flow_dir  (dir_ff),
         .present   (pm_ff[k]),
         .operand   (val_ff[k]),
         .stored    (agg_rdata[64*k +: 64]),
         .active    (slot_act[k]),
         .new_value (slot_new[k])
      );
      assign agg_wdata[64*k +: 64] = slot_new[k];
   end

   // Final result values, zero for slots that are not built.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rd_vals[k] = 64'd0;
      end
      for (int k = 0; k < SLOTS; k++) begin
         rd_vals[k] = res_val_ff[k];
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ridx_ok    = 17'(req_tdata[399:390]) < 17'(count_ff);
   assign match      = pend_ff && (key_rdata == key_ff);

   // Memory read addresses: in idle a read is issued straight from the request word, else from the scan registers.
   assign key_raddr = (state_ff == S_IDLE) ? IW'(req_tdata[399:390]) : scan_ff[IW-1:0];
   always_comb begin
      if (state_ff == S_IDLE) begin
         agg_raddr = IW'(req_tdata[399:390]);
      end else begin
         agg_raddr = pidx_ff;
      end
   end

   assign key_we = (state_ff == S_UPD) && !hit_ff;
   assign agg_we = (state_ff == S_UPD);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      dir_in       = dir_ff;
      pm_in        = pm_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      res_hit_in   = res_hit_ff;
      res_full_in  = res_full_ff;
      res_valid_in = res_valid_ff;
      res_pos_in   = res_pos_ff;
      res_key_in   = res_key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      for (int k = 0; k < SLOTS; k++) begin
         val_in[k]     = val_ff[k];
         res_val_in[k] = res_val_ff[k];
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_tuser;
               key_in  = KEY_BITS'({req_tdata[63:0], req_tdata[127:64]});
               dir_in  = req_tdata[129:128];
               pm_in   = req_tdata[133:130];
               for (int k = 0; k < SLOTS; k++) begin
                  val_in[k] = req_tdata[134 + 64*k +: 64];
               end
               scan_in      = '0;
               pend_in      = 1'b0;
               res_hit_in   = 1'b0;
               res_full_in  = 1'b0;
               res_valid_in = 1'b0;
               res_pos_in   = 10'd0;
               res_key_in   = 128'd0;
               for (int k = 0; k < SLOTS; k++) begin
                  res_val_in[k] = 64'd0;
               end
               case (req_tuser)
                  OP_READ: begin
                     res_pos_in = req_tdata[399:390];
                     state_in   = ridx_ok ? S_RD : S_FIN;
                  end
                  OP_OBSERVE, OP_MERGE: state_in = S_SCAN;
                  default:              state_in = S_FIN;
               endcase
            end
         end

         S_SCAN: begin
            if (match) begin
               hit_in   = 1'b1;
               idx_in   = pidx_ff;
               state_in = S_UPD;
            end else if (scan_ff < count_ff) begin
               pend_in = 1'b1;
               pidx_in = scan_ff[IW-1:0];
               scan_in = scan_ff + CW'(1);
            end else if (count_ff == CW'(ENTRIES)) begin
               res_full_in = 1'b1;
               state_in    = S_FIN;
            end else begin
               hit_in   = 1'b0;
               idx_in   = count_ff[IW-1:0];
               state_in = S_UPD;
            end
         end

         S_UPD: begin
            if (!hit_ff) begin
               count_in = count_ff + CW'(1);
            end
            res_hit_in   = hit_ff;
            res_valid_in = 1'b1;
            res_pos_in   = 10'(idx_ff);
            res_key_in   = 128'(key_ff);
            for (int k = 0; k < SLOTS; k++) begin
               res_val_in[k] = slot_act[k] ? slot_new[k] : 64'd0;
            end
            state_in = S_FIN;
         end

         S_RD: begin
            res_valid_in = 1'b1;
            res_key_in   = 128'(key_rdata);
            for (int k = 0; k < SLOTS; k++) begin
               res_val_in[k] = slot_act[k] ? agg_rdata[64*k +: 64] : 64'd0;
            end
            state_in = S_FIN;
         end

         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = {res_valid_ff, res_full_ff, res_hit_ff};
               rsp_data_in  = {6'd0, rd_vals[3], rd_vals[2], rd_vals[1], rd_vals[0],
                               res_key_ff[63:0], res_key_ff[127:64], res_pos_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         for (int k = 0; k < MODE_REGS; k++) begin
            mode_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_we) begin
            mode_ff[csr_index] <= slot_mode_type'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      dir_ff       <= dir_in;
      pm_ff        <= pm_in;
      scan_ff      <= scan_in;
      pidx_ff      <= pidx_in;
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      res_hit_ff   <= res_hit_in;
      res_full_ff  <= res_full_in;
      res_valid_ff <= res_valid_in;
      res_pos_ff   <= res_pos_in;
      res_key_ff   <= res_key_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      for (int k = 0; k < SLOTS; k++) begin
         val_ff[k]     <= val_in[k];
         res_val_ff[k] <= res_val_in[k];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== dv/flow_aggregation_table_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// flow_aggregation_table_checker
// Watches the request, result and mode-register ports of the flow table,
// keeps its own copy of the table and slot modes, and compares every result
// word field by field with the oldest predicted word.
// ============================================================================
module flow_aggregation_table_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [399:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [399:0] rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata,
   output int           error_count,
   output int           outstanding,
   output int           entries_used,
   output int           words_checked
);
   import fat_pkg::*;

   localparam int FIFO_DEPTH = 16;

   typedef struct packed {
      logic             hit;
      logic             full;
      logic             valid;
      logic [9:0]       pos;
      logic [63:0]      kh;
      logic [63:0]      kl;
      logic [3:0][63:0] val;
   } flow_result_type;

   // Predicted words waiting for their result, kept as a small ring.
   flow_result_type pending_results [FIFO_DEPTH];
   int              wr_ptr;
   int              rd_ptr;
   int              fill;
   logic [127:0]    flow_keys [ENTRIES_DEF];
   logic [63:0]     flow_aggs [ENTRIES_DEF][4];
   slot_mode_type   slot_modes [4];

   function automatic bit slot_active(int k);
      return slot_modes[k].kind inside {KIND_SUM, KIND_MIN, KIND_MAX, KIND_COUNT};
   endfunction

   function automatic logic [63:0] slot_mask(int k);
      if (slot_modes[k].kind == KIND_COUNT || slot_modes[k].width == WIDTH_64) begin
         return '1;
      end
      return (64'd1 << (8 << slot_modes[k].width)) - 64'd1;
   endfunction

   // Ordering compare at the slot width; signed slots flip the sign bit so an
   // unsigned compare gives the two's complement order.
   function automatic bit slot_below(int k, logic [63:0] a, logic [63:0] b);
      logic [63:0] m;
      m = slot_mask(k);
      a &= m;
      b &= m;
      if (slot_modes[k].sgn) begin
         a ^= (m >> 1) + 64'd1;
         b ^= (m >> 1) + 64'd1;
      end
      return a < b;
   endfunction

   function automatic logic [63:0] slot_start(int k);
      logic [63:0] m;
      m = slot_mask(k);
      if (slot_modes[k].kind == KIND_MIN) return slot_modes[k].sgn ? (m >> 1) : m;
      if (slot_modes[k].kind == KIND_MAX) begin
         return slot_modes[k].sgn ? (((m >> 1) + 64'd1) & m) : 64'd0;
      end
      return 64'd0;
   endfunction

   function automatic logic [63:0] slot_combine(int k, logic [63:0] acc, logic [63:0] v);
      logic [63:0] m;
      m = slot_mask(k);
      acc &= m;
      v &= m;
      case (slot_modes[k].kind)
         KIND_SUM, KIND_COUNT: return (acc + v) & m;
         KIND_MIN: return slot_below(k, v, acc) ? v : acc;
         KIND_MAX: return slot_below(k, acc, v) ? v : acc;
         default: return acc;
      endcase
   endfunction

   function automatic flow_result_type entry_image(int idx);
      flow_result_type r;
      r = '0;
      r.valid = 1'b1;
      r.pos = idx[9:0];
      r.kh = flow_keys[idx][127:64];
      r.kl = flow_keys[idx][63:0];
      for (int k = 0; k < 4; k++) r.val[k] = slot_active(k) ? flow_aggs[idx][k] : 64'd0;
      return r;
   endfunction

   // Applies one accepted request to the table copy and returns its result.
   function automatic flow_result_type apply_request(logic [1:0] op, logic [399:0] d);
      flow_result_type r;
      logic [127:0] key;
      logic [1:0]   dir;
      logic [3:0]   present;
      logic [9:0]   ridx;
      logic [63:0]  operand [4];
      int           idx;
      bit           hit;
      r = '0;
      key = {d[63:0], d[127:64]};
      dir = d[129:128];
      present = d[133:130];
      for (int k = 0; k < 4; k++) operand[k] = d[134 + 64 * k +: 64];
      ridx = d[399:390];
      if (op == OP_NONE) return r;
      if (op == OP_READ) begin
         if (int'(ridx) < entries_used) return entry_image(int'(ridx));
         r.pos = ridx;
         return r;
      end
      idx = -1;
      for (int i = 0; i < entries_used; i++) begin
         if (flow_keys[i] == key) begin
            idx = i;
            break;
         end
      end
      hit = (idx >= 0);
      if (!hit) begin
         if (entries_used >= ENTRIES_DEF) begin
            r.full = 1'b1;
            return r;
         end
         idx = entries_used;
         flow_keys[idx] = key;
         for (int k = 0; k < 4; k++) begin
            if (!slot_active(k)) flow_aggs[idx][k] = 64'd0;
            else if (op == OP_OBSERVE) flow_aggs[idx][k] = slot_start(k);
            else flow_aggs[idx][k] = operand[k] & slot_mask(k);
         end
         entries_used++;
      end
      for (int k = 0; k < 4; k++) begin
         if (!slot_active(k)) continue;
         if (op == OP_OBSERVE) begin
            if (slot_modes[k].dir != DIR_ANY && slot_modes[k].dir != dir) continue;
            if (slot_modes[k].kind == KIND_COUNT) flow_aggs[idx][k] += 64'd1;
            else if (present[k]) flow_aggs[idx][k] = slot_combine(k, flow_aggs[idx][k], operand[k]);
         end else if (hit) begin
            flow_aggs[idx][k] = slot_combine(k, flow_aggs[idx][k], operand[k]);
         end
      end
      r = entry_image(idx);
      r.hit = hit;
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("result field %s: expected %h, got %h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      flow_result_type want;
      flow_result_type fresh;
      if (reset) begin
         wr_ptr = 0;
         rd_ptr = 0;
         fill = 0;
         entries_used = 0;
         error_count = 0;
         words_checked = 0;
         for (int k = 0; k < 4; k++) slot_modes[k] = '0;
      end else begin
         if (csr_we) slot_modes[csr_index] = slot_mode_type'(csr_wdata);
         if (req_tvalid && req_tready) begin
            fresh = apply_request(req_tuser, req_tdata);
            if (fill == FIFO_DEPTH) begin
               $error("more request words in flight than the checker can hold");
               error_count++;
            end else begin
               pending_results[wr_ptr] = fresh;
               wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
               fill++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (fill == 0) begin
               $error("result word arrived with no request waiting for it");
               error_count++;
            end else begin
               want = pending_results[rd_ptr];
               rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
               fill--;
               words_checked++;
               check_field("hit", 64'(want.hit), 64'(rsp_tuser[0]));
               check_field("table_full", 64'(want.full), 64'(rsp_tuser[1]));
               check_field("entry_valid", 64'(want.valid), 64'(rsp_tuser[2]));
               check_field("entry_position", 64'(want.pos), 64'(rsp_tdata[9:0]));
               check_field("out_key_high", want.kh, rsp_tdata[73:10]);
               check_field("out_key_low", want.kl, rsp_tdata[137:74]);
               check_field("out_value_a", want.val[0], rsp_tdata[138 +: 64]);
               check_field("out_value_b", want.val[1], rsp_tdata[202 +: 64]);
               check_field("out_value_c", want.val[2], rsp_tdata[266 +: 64]);
               check_field("out_value_d", want.val[3], rsp_tdata[330 +: 64]);
            end
         end
      end
      outstanding = fill;
   end

endmodule

// ===== dv/flow_aggregation_table_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// flow_aggregation_table_top_tb
// Drives observe, merge, read and unused-operation words into the flow table
// under several slot-mode settings and idle patterns, then fills the table to
// its limit; a separate checker predicts and compares every result word.
// ============================================================================
module flow_aggregation_table_top_tb;
   import fat_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [399:0] req_tdata = '0;
   logic [1:0]   req_tuser = OP_NONE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [399:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [7:0]   csr_wdata = '0;

   int error_count;
   int outstanding;
   int entries_used;
   int words_checked;

   // Idle controls shared by the sender and the receiver.
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int words_sent = 0;

   logic [127:0] key_pool [32];

   flow_aggregation_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   flow_aggregation_table_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .outstanding   (outstanding),
      .entries_used  (entries_used),
      .words_checked (words_checked)
   );

   always #4 clock = ~clock;

   // The receiver either stalls at random or, when a long hold-off has been
   // requested, keeps tready low for a counted number of cycles so that the
   // block backs up and stops taking request words.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Hard stop in case the block hangs; the slowest correct run, including
   // the fill to the last entry, is several times shorter.
   initial begin
      #40_000_000;
      $display("flow_aggregation_table_top_tb: done, errors");
      $finish;
   end

   // Offers one request word, optionally after a random gap. tready is looked
   // at on the falling edge, where it already holds the value that the next
   // rising edge sees.
   task automatic send_word(input logic [1:0] op, input logic [127:0] key,
                            input logic [1:0] dir, input logic [3:0] present,
                            input logic [255:0] operands, input logic [9:0] ridx);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {ridx, operands, present, dir, key[63:0], key[127:64]};
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      words_sent++;
   endtask

   // Lets everything in flight come back, then writes all four slot modes.
   task automatic program_modes(input logic [7:0] m0, input logic [7:0] m1,
                                input logic [7:0] m2, input logic [7:0] m3);
      logic [7:0] modes [4];
      modes = '{m0, m1, m2, m3};
      @(posedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= i[1:0];
         csr_wdata <= modes[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Operand values lean on the corners where sums wrap and compares flip.
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(5))
         0: return 64'd0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000 >> (8 * $urandom_range(7));
         3: return 64'h7FFF_FFFF_FFFF_FFFF >> (8 * $urandom_range(7));
         4: return 64'($urandom_range(255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [255:0] pick_operands();
      return {pick_operand(), pick_operand(), pick_operand(), pick_operand()};
   endfunction

   function automatic logic [127:0] fresh_key();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [7:0] random_mode();
      return 8'($urandom_range(255));
   endfunction

   // Random traffic: mostly observes and merges on a small set of recurring
   // flows so that entries get folded many times, with fresh flows, reads
   // and the unused operation mixed in.
   task automatic random_words(input int count);
      int sel;
      logic [127:0] key;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(31)] : fresh_key();
         if (sel < 50) begin
            send_word(OP_OBSERVE, key, 2'($urandom_range(3)), 4'($urandom_range(15)),
                      pick_operands(), 10'($urandom_range(1023)));
         end else if (sel < 75) begin
            send_word(OP_MERGE, key, 2'($urandom_range(3)), 4'($urandom_range(15)),
                      pick_operands(), 10'($urandom_range(1023)));
         end else if (sel < 95) begin
            send_word(OP_READ, fresh_key(), 2'($urandom_range(3)), 4'($urandom_range(15)),
                      pick_operands(),
                      ($urandom_range(1)) ? 10'($urandom_range(entries_used + 2))
                                          : 10'($urandom_range(1023)));
         end else begin
            send_word(OP_NONE, fresh_key(), 2'($urandom_range(3)), 4'($urandom_range(15)),
                      pick_operands(), 10'($urandom_range(1023)));
         end
      end
   endtask

   initial begin
      logic [127:0] k_zero;
      logic [127:0] k_ones;
      logic [127:0] k_two;
      logic [127:0] k_three;
      k_zero = '0;
      k_ones = '1;
      k_two = fresh_key();
      k_three = fresh_key();
      for (int i = 0; i < 32; i++) key_pool[i] = fresh_key();
      key_pool[0] = k_zero;
      key_pool[1] = k_ones;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Slot one sums unsigned bytes, slot two takes a signed
      // 16-bit minimum, slot three a signed 64-bit maximum of inbound flows
      // only, and slot four counts outbound flows.
      program_modes(8'h01, 8'h1A, 8'h7B, 8'h84);
      send_word(OP_OBSERVE, k_zero, 2'd1, 4'hF,
                {64'd9, 64'h8000_0000_0000_0000, 64'h8000, 64'h1FF}, '0);
      send_word(OP_OBSERVE, k_zero, 2'd2, 4'hF,
                {64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF, 64'hFF}, '0);
      send_word(OP_OBSERVE, k_ones, 2'd0, 4'h0, '1, '0);
      send_word(OP_OBSERVE, k_ones, 2'd3, 4'hF, '1, '1);
      send_word(OP_MERGE, k_two, 2'd3, 4'h0, '1, '0);
      send_word(OP_MERGE, k_two, 2'd0, 4'hF, '0, '0);
      send_word(OP_MERGE, k_zero, 2'd1, 4'h5, pick_operands(), '0);
      send_word(OP_READ, k_ones, 2'd0, 4'h0, '0, 10'd0);
      send_word(OP_READ, '0, 2'd0, 4'h0, '0, 10'd2);
      send_word(OP_READ, '0, 2'd0, 4'h0, '0, 10'd3);
      send_word(OP_READ, '1, 2'd3, 4'hF, '1, 10'd1023);
      send_word(OP_NONE, '1, 2'd3, 4'hF, '1, '1);

      // A mode change keeps the stored bits and reinterprets them.
      program_modes(8'h02, 8'h23, 8'h39, 8'hCA);
      send_word(OP_OBSERVE, k_zero, 2'd3, 4'hF, pick_operands(), '0);
      send_word(OP_OBSERVE, k_three, 2'd3, 4'hF, pick_operands(), '0);
      send_word(OP_MERGE, k_three, 2'd0, 4'h0, pick_operands(), '0);
      send_word(OP_READ, '0, 2'd0, 4'h0, '0, 10'd0);

      // Every slot inactive, then every slot with kind bits that mean none.
      program_modes(8'h00, 8'h00, 8'h00, 8'h00);
      send_word(OP_OBSERVE, k_zero, 2'd1, 4'hF, '1, '0);
      send_word(OP_MERGE, fresh_key(), 2'd1, 4'hF, '1, '0);
      program_modes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_word(OP_MERGE, k_ones, 2'd2, 4'hF, '1, '0);
      send_word(OP_READ, '0, 2'd0, 4'h0, '0, 10'd1);

      // Random phases, each under its own slot modes and idle pattern.
      program_modes(random_mode(), random_mode(), random_mode(), random_mode());
      random_words(150);
      program_modes(8'h0B, 8'h2C, 8'h14, 8'h3A);
      send_idle_pct = 50;
      random_words(150);
      program_modes(random_mode(), random_mode(), random_mode(), random_mode());
      send_idle_pct = 0;
      stall_pct = 50;
      random_words(150);
      program_modes(8'h31, 8'hB3, 8'h7A, 8'h44);
      send_idle_pct = 10;
      stall_pct = 10;
      random_words(150);

      // Long receiver hold-off while the sender keeps offering words.
      program_modes(random_mode(), random_mode(), random_mode(), random_mode());
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = 400;
      random_words(150);

      // Fill every entry with new flows, then push new keys past the limit.
      program_modes(8'h04, 8'h01, 8'h22, 8'h3B);
      while (entries_used < ENTRIES_DEF) begin
         send_word(OP_OBSERVE, fresh_key(), 2'($urandom_range(3)), 4'($urandom_range(15)),
                   pick_operands(), '0);
      end
      send_word(OP_OBSERVE, fresh_key(), 2'd1, 4'hF, pick_operands(), '0);
      send_word(OP_MERGE, fresh_key(), 2'd2, 4'hF, pick_operands(), '0);
      send_word(OP_OBSERVE, k_zero, 2'd1, 4'hF, pick_operands(), '0);
      send_word(OP_READ, '0, 2'd0, 4'h0, '0, 10'd1023);
      send_word(OP_READ, '0, 2'd0, 4'h0, '0, 10'($urandom_range(1023)));

      @(posedge clock);
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (20) @(posedge clock);

      $display("Sent %0d request words under ten slot-mode settings and five idle patterns;",
               words_sent);
      $display("checked %0d result words and filled %0d entries up to the table limit.",
               words_checked, entries_used);
      if (error_count == 0 && outstanding == 0) begin
         $display("flow_aggregation_table_top_tb: done, clean");
      end else begin
         $display("flow_aggregation_table_top_tb: done, errors");
      end
      $finish;
   end

endmodule
